// ----- rtl/core/life_generation_row_engine_assert.svh -----
// Assertion helpers for the row engine checker.
`ifndef LIFE_GENERATION_ROW_ENGINE_ASSERT_SVH
`define LIFE_GENERATION_ROW_ENGINE_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define LGR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LGR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/core/lgr_pkg.sv -----
package lgr_pkg;

   localparam int ROW_BITS      = 64;
   localparam int WIDTH_BITS    = 7;
   localparam int MAX_ROW_CELLS = 64;
   localparam int BORN_COUNT    = 3;
   localparam int STAY_COUNT    = 2;
   localparam int CMD_DEPTH     = 2;
   localparam int RSP_DEPTH     = 2;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);

   typedef struct packed {
      logic [ROW_BITS-1:0] in_row;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] out_row;
      logic                out_last;
   } rsp_type;

   // One accepted row with the neighborhood it needs.
   typedef struct packed {
      logic [ROW_BITS-1:0] up_row;
      logic [ROW_BITS-1:0] mid_row;
      logic [ROW_BITS-1:0] cur_row;
      logic                held_valid;
      logic                last;
   } cmd_type;

   function automatic logic [ROW_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] c;
      c = (w > WIDTH_BITS'(MAX_ROW_CELLS)) ? WIDTH_BITS'(MAX_ROW_CELLS) : w;
      if (c >= WIDTH_BITS'(ROW_BITS)) begin
         return '1;
      end
      return (ROW_BITS'(1) << c) - ROW_BITS'(1);
   endfunction

   // B3/S23 over 64 independent lanes; no wrap at either row end.
   function automatic logic [ROW_BITS-1:0] next_row(input logic [ROW_BITS-1:0] up,
                                                    input logic [ROW_BITS-1:0] mid,
                                                    input logic [ROW_BITS-1:0] down);
      logic [ROW_BITS+1:0] u;
      logic [ROW_BITS+1:0] m;
      logic [ROW_BITS+1:0] d;
      logic [3:0]          cnt;
      logic [ROW_BITS-1:0] r;
      u = {1'b0, up, 1'b0};
      m = {1'b0, mid, 1'b0};
      d = {1'b0, down, 1'b0};
      r = '0;
      for (int k = 0; k < ROW_BITS; k++) begin
         cnt = 4'(u[k]) + 4'(u[k+2]) + 4'(up[k]) + 4'(m[k]) + 4'(m[k+2])
             + 4'(d[k]) + 4'(d[k+2]) + 4'(down[k]);
         r[k] = (cnt == 4'(BORN_COUNT)) || (mid[k] && (cnt == 4'(STAY_COUNT)));
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/lgr_fifo.sv -----
module lgr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/lgr_front.sv -----
module lgr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  lgr_pkg::req_type                   req_data,
   input  logic                               csr_write,
   input  logic [lgr_pkg::WIDTH_BITS-1:0]     csr_data,
   output lgr_pkg::cmd_type                   cmd_data,
   output logic [lgr_pkg::ROW_BITS-1:0]       mask
);

   logic [lgr_pkg::WIDTH_BITS-1:0] width_ff, width_in;
   logic [lgr_pkg::ROW_BITS-1:0]   above_ff, above_in;
   logic [lgr_pkg::ROW_BITS-1:0]   held_ff, held_in;
   logic                           held_valid_ff, held_valid_in;
   logic [lgr_pkg::ROW_BITS-1:0]   cur_row;

   assign mask    = lgr_pkg::width_mask(width_ff);
   assign cur_row = req_data.in_row & mask;

   assign cmd_data.up_row     = above_ff;
   assign cmd_data.mid_row    = held_ff;
   assign cmd_data.cur_row    = cur_row;
   assign cmd_data.held_valid = held_valid_ff;
   assign cmd_data.last       = req_data.frame_end;

   always_comb begin
      width_in      = csr_write ? csr_data : width_ff;
      above_in      = above_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            // bottom row closes the frame: back to a dead border
            above_in      = '0;
            held_in       = '0;
            held_valid_in = 1'b0;
         end else begin
            above_in      = held_valid_ff ? held_ff : above_ff;
            held_in       = cur_row;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lgr_pkg::WIDTH_RESET;
         above_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         above_ff      <= above_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

// ----- rtl/core/lgr_back.sv -----
module lgr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_empty,
   input  lgr_pkg::cmd_type             cmd_data,
   output logic                         cmd_pop,
   input  logic                         res_full,
   output logic                         res_push,
   output lgr_pkg::rsp_type             res_data,
   input  logic [lgr_pkg::ROW_BITS-1:0] mask
);

   typedef enum logic [1:0] {
      PH_FIRST  = 2'b01,
      PH_SECOND = 2'b10
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic                         first;
   logic                         need;
   logic [lgr_pkg::ROW_BITS-1:0] up, mid, down;

   always_comb begin
      case (phase_ff)
         PH_FIRST:  first = cmd_data.held_valid;
         PH_SECOND: first = 1'b0;
         default:   first = 1'b0;
      endcase
   end

   // first result: held row over the new row; second: new row over dead space
   assign up   = first ? cmd_data.up_row :
                 (cmd_data.held_valid ? cmd_data.mid_row : cmd_data.up_row);
   assign mid  = first ? cmd_data.mid_row : cmd_data.cur_row;
   assign down = first ? cmd_data.cur_row : '0;

   assign res_data.out_row  = lgr_pkg::next_row(up, mid, down) & mask;
   assign res_data.out_last = !first;

   assign need     = cmd_data.held_valid || cmd_data.last;
   assign res_push = !cmd_empty && need && !res_full;
   assign cmd_pop  = !cmd_empty && (!need || (!res_full && !(first && cmd_data.last)));

   always_comb begin
      phase_in = phase_ff;
      if (res_push && first && cmd_data.last) begin
         phase_in = PH_SECOND;
      end else if (cmd_pop) begin
         phase_in = PH_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/core/life_generation_row_engine.sv -----
// Life row engine: one generation of B3/S23 over a bounded grid, streamed one
// row per transaction, top row first, with dead space on every side and no
// wrap. A row's next state appears once the row below it has been pushed; a
// frame_end row also yields its own result (out_last set) and resets the row
// history for the next frame. Rows are accepted back to back while the back
// end keeps pace. Each row's result is computed combinationally by 64
// parallel neighbor-count lanes in the back end, and a frame_end row that
// also releases the row above it holds the back end through both of its
// phases (one per result); a stream of such frames is taken at less than
// one row per cycle once the command queue fills. A result passes through
// the command queue and the result queue before it becomes visible.
// row_width is written through csr_data and should change only while no
// results are outstanding.
module life_generation_row_engine #(
   parameter int CMD_DEPTH = lgr_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = lgr_pkg::RSP_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // row input queue
   input  logic                           req_push,
   output logic                           req_full,
   input  lgr_pkg::req_type               req_data,
   // result queue
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output lgr_pkg::rsp_type               rsp_data,
   // row_width register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lgr_pkg::WIDTH_BITS-1:0] csr_data
);

   lgr_pkg::cmd_type             front_cmd;
   lgr_pkg::cmd_type             back_cmd;
   lgr_pkg::rsp_type             back_res;
   logic [lgr_pkg::ROW_BITS-1:0] mask;
   logic                         accept;
   logic                         cmd_empty, cmd_pop;
   logic                         res_full, res_push;

   // register write is always taken
   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // front: masks the incoming row and tracks the two rows above it
   lgr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd_data  (front_cmd),
      .mask      (mask)
   );

   // command queue decouples accept from evaluation
   lgr_fifo #(
      .WIDTH ($bits(lgr_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   // back: evaluates up to two results per command
   lgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (back_res),
      .mask      (mask)
   );

   // result queue doubles as the output register
   lgr_fifo #(
      .WIDTH ($bits(lgr_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

// ----- rtl/core/lgr_checker.sv -----
`include "life_generation_row_engine_assert.svh"

module lgr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input lgr_pkg::rsp_type rsp_data
);

   // both queues come out of reset with nothing in them
   `LGR_ASSERT_ALWAYS(a_reset_clears, reset |=> (rsp_empty && !req_full), "queues not empty after reset")

   // the input side fills only through an accepted transaction
   `LGR_ASSERT(a_full_by_push, $rose(req_full) |-> $past(req_push && !req_full), "full rose without a push")

   // a waiting result holds until taken
   `LGR_ASSERT(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "stalled result changed")

endmodule

bind life_generation_row_engine lgr_checker u_checker (.*);

// ----- verif/life_generation_row_engine_checker.sv -----
module life_generation_row_engine_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  lgr_pkg::req_type               req_data,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  lgr_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lgr_pkg::WIDTH_BITS-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [lgr_pkg::WIDTH_BITS-1:0] width_now;
   logic [lgr_pkg::ROW_BITS-1:0]   row_above;
   logic [lgr_pkg::ROW_BITS-1:0]   row_held;
   logic                           row_waiting;
   lgr_pkg::rsp_type               next_rows[$];

   // cells at or past the width are dead; widths past the row clamp to it
   function automatic logic [lgr_pkg::ROW_BITS-1:0] live_cells(
         input logic [lgr_pkg::WIDTH_BITS-1:0] w);
      int n;
      n = (int'(w) > lgr_pkg::MAX_ROW_CELLS) ? lgr_pkg::MAX_ROW_CELLS : int'(w);
      if (n >= lgr_pkg::ROW_BITS) begin
         return '1;
      end
      return (lgr_pkg::ROW_BITS'(1) << n) - lgr_pkg::ROW_BITS'(1);
   endfunction

   function automatic logic [lgr_pkg::ROW_BITS-1:0] evolve(
         input logic [lgr_pkg::ROW_BITS-1:0]   up,
         input logic [lgr_pkg::ROW_BITS-1:0]   mid,
         input logic [lgr_pkg::ROW_BITS-1:0]   down,
         input logic [lgr_pkg::WIDTH_BITS-1:0] w);
      logic [lgr_pkg::ROW_BITS-1:0] gen;
      int                           nbrs;
      int                           j;
      gen = '0;
      for (int k = 0; k < lgr_pkg::ROW_BITS; k++) begin
         nbrs = 0;
         for (int dk = -1; dk <= 1; dk++) begin
            j = k + dk;
            if (j >= 0 && j < lgr_pkg::ROW_BITS) begin
               nbrs += int'(up[j]) + int'(down[j]);
               if (dk != 0) begin
                  nbrs += int'(mid[j]);
               end
            end
         end
         gen[k] = (nbrs == lgr_pkg::BORN_COUNT) || (mid[k] && nbrs == lgr_pkg::STAY_COUNT);
      end
      return gen & live_cells(w);
   endfunction

   always @(posedge clock) begin
      lgr_pkg::rsp_type             want;
      lgr_pkg::rsp_type             item;
      logic [lgr_pkg::ROW_BITS-1:0] incoming;
      if (reset) begin
         width_now   = lgr_pkg::WIDTH_RESET;
         row_above   = '0;
         row_held    = '0;
         row_waiting = 1'b0;
         next_rows.delete();
         fail_count  = 0;
      end else begin
         // result side first: a result can never stem from a row taken at this edge
         if (!rsp_empty && rsp_pop) begin
            if (next_rows.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual row %h last %b",
                        $time, rsp_data.out_row, rsp_data.out_last);
               fail_count++;
            end else begin
               want = next_rows.pop_front();
               if (rsp_data.out_row !== want.out_row) begin
                  $display("%0t: out_row mismatch, expected %h, actual %h",
                           $time, want.out_row, rsp_data.out_row);
                  fail_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $display("%0t: out_last mismatch, expected %b, actual %b",
                           $time, want.out_last, rsp_data.out_last);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            incoming = req_data.in_row & live_cells(width_now);
            if (row_waiting) begin
               item.out_row  = evolve(row_above, row_held, incoming, width_now);
               item.out_last = 1'b0;
               next_rows     = {next_rows, item};
               row_above     = row_held;
            end
            row_held    = incoming;
            row_waiting = 1'b1;
            if (req_data.frame_end) begin
               item.out_row  = evolve(row_above, incoming, '0, width_now);
               item.out_last = 1'b1;
               next_rows     = {next_rows, item};
               row_above     = '0;
               row_held      = '0;
               row_waiting   = 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            width_now = csr_data;
         end
      end
      pending_count = next_rows.size();
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // run length: covers the random gaps before each row and before each of its
   // results, plus the long receiver hold and the settle time around csr writes
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ROWS   = 1150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;

   logic                           clock;
   logic                           reset;
   logic                           req_push;
   logic                           req_full;
   lgr_pkg::req_type               req_data;
   logic                           rsp_empty;
   logic                           rsp_pop;
   lgr_pkg::rsp_type               rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [lgr_pkg::WIDTH_BITS-1:0] csr_data;

   int fail_count;
   int pending_count;
   int cycle_count;
   int rows_sent;

   // set by the sender: no-idle stretches, long result hold
   logic burst_mode;
   logic hold_request;

   life_generation_row_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   life_generation_row_engine_checker row_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog: a hung handshake or a missing result ends here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Push one row. Entered and left at a falling edge; push stays high across
   // back-to-back transactions when the drawn gap is zero.
   task automatic push_row(input logic [lgr_pkg::ROW_BITS-1:0] cells, input logic bottom);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = '{in_row: cells, frame_end: bottom};
      do @(posedge clock); while (req_full);
      rows_sent++;
      @(negedge clock);
   endtask

   // Let every outstanding result drain, give the back end a settle time,
   // then do one csr transaction.
   task automatic write_width(input logic [lgr_pkg::WIDTH_BITS-1:0] w);
      req_push = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Row content: plain random, sparse, dense, a pattern hugging the edges, or an empty, full or single-cell row.
   function automatic logic [lgr_pkg::ROW_BITS-1:0] random_cells();
      logic [lgr_pkg::ROW_BITS-1:0] a;
      logic [lgr_pkg::ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: begin
            return a & b & {$urandom, $urandom};
         end
         1: begin
            return a | b;
         end
         2: begin
            // live cells at both row ends, where a wrap would show
            return (a & 64'hE000_0000_0000_0007) | (b & {$urandom, $urandom});
         end
         3: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return '1;
               default: return lgr_pkg::ROW_BITS'(1)
                               << $urandom_range(0, lgr_pkg::ROW_BITS - 1);
            endcase
         end
         default: begin
            return a;
         end
      endcase
   endfunction

   // mostly in-range widths, with zero, full and over-range mixed in
   function automatic logic [lgr_pkg::WIDTH_BITS-1:0] random_width();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return lgr_pkg::WIDTH_BITS'(lgr_pkg::MAX_ROW_CELLS);
         2: return lgr_pkg::WIDTH_BITS'($urandom_range(lgr_pkg::MAX_ROW_CELLS + 1, 127));
         3: return lgr_pkg::WIDTH_BITS'($urandom_range(1, 3));
         default: return lgr_pkg::WIDTH_BITS'($urandom_range(1, lgr_pkg::MAX_ROW_CELLS));
      endcase
   endfunction

   // Receiver: random pop gaps, zero in bursts, and one long hold on request.
   initial begin
      int   gap;
      logic hold_done;
      hold_done = 1'b0;
      rsp_pop   = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         gap = burst_mode ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   // Sender: reset, directed frames, random frames, drain, verdict.
   initial begin
      int frame_len;
      int frame_no;
      req_push     = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      burst_mode   = 1'b0;
      hold_request = 1'b0;
      rows_sent    = 0;
      reset        = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // reset width: a lone bottom row, full of life, has only its own result
      push_row('1, 1'b1);
      // three-row frame: full, empty, full
      push_row('1, 1'b0);
      push_row('0, 1'b0);
      push_row('1, 1'b1);
      // cells at both row ends: any wrap across the row ends would show
      push_row(64'hC000_0000_0000_0003, 1'b0);
      push_row(64'h8000_0000_0000_0001, 1'b0);
      push_row(64'hC000_0000_0000_0003, 1'b1);
      // width zero: everything dead
      write_width('0);
      push_row('1, 1'b0);
      push_row(64'h0000_0000_0000_0007, 1'b1);
      // width above range behaves as the full row
      write_width('1);
      push_row('1, 1'b0);
      push_row(64'h5555_5555_AAAA_AAAA, 1'b1);
      // width one: a single column
      write_width(lgr_pkg::WIDTH_BITS'(1));
      push_row('1, 1'b0);
      push_row('1, 1'b0);
      push_row('1, 1'b1);
      // width changed while a row is held: the held row's result uses the new one
      write_width(lgr_pkg::WIDTH_BITS'(lgr_pkg::MAX_ROW_CELLS));
      push_row('1, 1'b0);
      write_width(lgr_pkg::WIDTH_BITS'(10));
      push_row('1, 1'b1);
      // one frame with no idling on either side
      burst_mode = 1'b1;
      push_row(64'h0000_0000_0000_0070, 1'b0);
      push_row(64'h0000_0000_0000_0070, 1'b0);
      push_row(64'h0000_0000_0000_0070, 1'b1);
      burst_mode = 1'b0;

      // --- random frames ---
      frame_no = 0;
      while (rows_sent < RANDOM_ROWS) begin
         if (frame_no % 5 == 0) begin
            write_width(random_width());
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         // most frames short, a few tall
         frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
         for (int r = 0; r < frame_len; r++) begin
            // long result hold while rows keep coming, so the block backs up
            if (rows_sent == 300) begin
               hold_request = 1'b1;
            end
            push_row(random_cells(), r == frame_len - 1);
            // occasional width change with a row held mid-frame
            if (r == 0 && frame_len > 1 && $urandom_range(0, 19) == 0) begin
               write_width(random_width());
            end
         end
         // sender pause until everything has come back
         if (frame_no == 60) begin
            req_push = 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         frame_no++;
      end
      burst_mode = 1'b0;

      // --- drain ---
      req_push = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
